>>> sv/range_sum_segment_tree_defines.svh
// assertion macros for the range sum segment tree
// used by the top level only, no dependencies
`ifndef RANGE_SUM_SEGMENT_TREE_DEFINES_SVH
`define RANGE_SUM_SEGMENT_TREE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RSST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rsst check failed");

// next-cycle implication, checked outside reset
`define RSST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rsst check failed");

`endif

>>> sv/rsst_pkg.sv
// shared constants, types and state codes for the range sum segment tree
// no dependencies
package rsst_pkg;

	localparam int LEAVES     = 1024;
	localparam int NODE_COUNT = 2 * LEAVES;
	localparam int LEVELS     = $clog2(LEAVES);
	localparam int NODE_W     = LEVELS + 1;
	localparam int PTR_W      = NODE_W + 1;
	localparam int POS_W      = 10;
	localparam int VAL_W      = 32;
	localparam int SUM_W      = 42;
	localparam int IDX_W      = (POS_W > PTR_W) ? POS_W : PTR_W;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD_LEAF,
		ST_UPD_SUM,
		ST_UPD_RD,
		ST_QUERY
	} state_t;

	typedef struct packed {
		logic              we;
		logic [NODE_W-1:0] waddr;
		logic [SUM_W-1:0]  wdata;
		logic              re;
		logic [NODE_W-1:0] raddr;
	} mem_req_t;

endpackage

>>> sv/rsst_ram.sv
// node store of the tree: one write port, one read port, registered read data
// depends on rsst_pkg
module rsst_ram (
	input  logic                              clk,
	input  rsst_pkg::mem_req_t                req,
	output logic [rsst_pkg::SUM_W-1:0]        rdata
);

	logic [rsst_pkg::SUM_W-1:0] mem [rsst_pkg::NODE_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

>>> sv/rsst_walker.sv
// sequencer for clearing, leaf update with ancestor rebuild, and range query
// depends on rsst_pkg; drives the node store through a mem_req_t
module rsst_walker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [rsst_pkg::POS_W-1:0]        position,
	input  logic [rsst_pkg::VAL_W-1:0]        new_value,
	input  logic [rsst_pkg::POS_W-1:0]        range_left,
	input  logic [rsst_pkg::POS_W-1:0]        range_right,
	output logic                              done,
	output logic [rsst_pkg::SUM_W-1:0]        range_sum,
	output rsst_pkg::mem_req_t                mem_req,
	input  logic [rsst_pkg::SUM_W-1:0]        mem_rdata
);

	localparam int NODE_W = rsst_pkg::NODE_W;
	localparam int PTR_W  = rsst_pkg::PTR_W;
	localparam int IDX_W  = rsst_pkg::IDX_W;
	localparam int SUM_W  = rsst_pkg::SUM_W;

	rsst_pkg::state_t state_q, state_d;
	logic [NODE_W-1:0] clr_q, clr_d;
	logic [NODE_W-1:0] k_q, k_d;
	logic [PTR_W-1:0]  lo_q, lo_d, hi_q, hi_d;
	logic [SUM_W-1:0]  cur_q, cur_d, acc_q, acc_d;
	logic              pend_s1, pend_d;
	logic              done_q, done_d;
	logic [SUM_W-1:0]  sum_q, sum_d;

	logic [IDX_W-1:0]  right_sat;
	logic [IDX_W-1:0]  left_ext;
	logic [SUM_W-1:0]  acc_now;
	logic [NODE_W-1:0] parent;
	logic [PTR_W-1:0]  hi_dec;

	always_comb begin
		left_ext = IDX_W'(range_left);
		if (IDX_W'(range_right) >= IDX_W'(rsst_pkg::LEAVES)) begin
			right_sat = IDX_W'(rsst_pkg::LEAVES - 1);
		end else begin
			right_sat = IDX_W'(range_right);
		end
		acc_now = pend_s1 ? (acc_q + mem_rdata) : acc_q;
		parent  = k_q >> 1;
		hi_dec  = hi_q - PTR_W'(1);
	end

	always_comb begin
		state_d = state_q;
		clr_d   = clr_q;
		k_d     = k_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		cur_d   = cur_q;
		acc_d   = acc_q;
		pend_d  = 1'b0;
		done_d  = 1'b0;
		sum_d   = sum_q;
		mem_req = '0;
		unique case (state_q)
			rsst_pkg::ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = clr_q;
				clr_d         = clr_q + NODE_W'(1);
				if (clr_q == NODE_W'(rsst_pkg::NODE_COUNT - 1)) begin
					state_d = rsst_pkg::ST_IDLE;
				end
			end
			rsst_pkg::ST_IDLE: begin
				if (start) begin
					if (operation == rsst_pkg::OP_UPDATE) begin
						if (IDX_W'(position) < IDX_W'(rsst_pkg::LEAVES)) begin
							k_d     = NODE_W'(IDX_W'(position) + IDX_W'(rsst_pkg::LEAVES));
							cur_d   = SUM_W'(new_value);
							state_d = rsst_pkg::ST_UPD_LEAF;
						end
					end else begin
						acc_d   = '0;
						state_d = rsst_pkg::ST_QUERY;
						if (left_ext > right_sat) begin
							lo_d = '0;
							hi_d = '0;
						end else begin
							lo_d = PTR_W'(left_ext + IDX_W'(rsst_pkg::LEAVES));
							hi_d = PTR_W'(right_sat + IDX_W'(rsst_pkg::LEAVES + 1));
						end
					end
				end
			end
			rsst_pkg::ST_UPD_LEAF: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = k_q;
				mem_req.wdata = cur_q;
				mem_req.re    = 1'b1;
				mem_req.raddr = k_q ^ NODE_W'(1);
				state_d       = rsst_pkg::ST_UPD_SUM;
			end
			rsst_pkg::ST_UPD_SUM: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = parent;
				mem_req.wdata = cur_q + mem_rdata;
				cur_d         = cur_q + mem_rdata;
				k_d           = parent;
				if (parent == NODE_W'(1)) begin
					state_d = rsst_pkg::ST_IDLE;
				end else begin
					state_d = rsst_pkg::ST_UPD_RD;
				end
			end
			rsst_pkg::ST_UPD_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = k_q ^ NODE_W'(1);
				state_d       = rsst_pkg::ST_UPD_SUM;
			end
			rsst_pkg::ST_QUERY: begin
				acc_d = acc_now;
				if (lo_q >= hi_q) begin
					done_d  = 1'b1;
					sum_d   = acc_now;
					state_d = rsst_pkg::ST_IDLE;
				end else if (lo_q[0]) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = lo_q[NODE_W-1:0];
					pend_d        = 1'b1;
					lo_d          = lo_q + PTR_W'(1);
				end else if (hi_q[0]) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = hi_dec[NODE_W-1:0];
					pend_d        = 1'b1;
					lo_d          = lo_q >> 1;
					hi_d          = hi_dec >> 1;
				end else begin
					lo_d = lo_q >> 1;
					hi_d = hi_q >> 1;
				end
			end
			default: begin
				state_d = rsst_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsst_pkg::ST_CLEAR;
			clr_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			pend_s1 <= pend_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q   <= k_d;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		cur_q <= cur_d;
		acc_q <= acc_d;
		sum_q <= sum_d;
	end

	assign busy      = (state_q != rsst_pkg::ST_IDLE);
	assign done      = done_q;
	assign range_sum = sum_q;

endmodule

>>> sv/range_sum_segment_tree.sv
// update: busy for the leaf write, then one read and one write per ancestor
// query: busy while nodes are read, at most one at a time, on the single
// read port; done rises at the edge where busy falls; start is taken only when idle
// after reset busy stays high while the node store is swept to zero
// results are shown for one cycle with done and are never held off; an update gives none
// top level: range sum segment tree over the node store
// depends on rsst_pkg, rsst_ram, rsst_walker and range_sum_segment_tree_defines.svh
`include "range_sum_segment_tree_defines.svh"

module range_sum_segment_tree (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              operation,
	input  logic [rsst_pkg::POS_W-1:0]        position,
	input  logic [rsst_pkg::VAL_W-1:0]        new_value,
	input  logic [rsst_pkg::POS_W-1:0]        range_left,
	input  logic [rsst_pkg::POS_W-1:0]        range_right,
	output logic                              done,
	output logic [rsst_pkg::SUM_W-1:0]        range_sum
);

	rsst_pkg::mem_req_t         mem_req;
	logic [rsst_pkg::SUM_W-1:0] mem_rdata;

	rsst_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.position    (position),
		.new_value   (new_value),
		.range_left  (range_left),
		.range_right (range_right),
		.done        (done),
		.range_sum   (range_sum),
		.mem_req     (mem_req),
		.mem_rdata   (mem_rdata)
	);

	rsst_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	`RSST_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`RSST_ASSERT_SAME(a_done_after_busy, clk, arst_n, done, $past(busy))
	`RSST_ASSERT_NEXT(a_query_busy, clk, arst_n, start && !busy && operation == rsst_pkg::OP_QUERY, busy)
	`RSST_ASSERT_SAME(a_no_rw_collide, clk, arst_n, mem_req.we && mem_req.re, mem_req.waddr != mem_req.raddr)

endmodule
